### rtl/core/tdpt_pkg.sv
// Shared types for the trial division prime test block.
`default_nettype none

package tdpt_pkg;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLASS = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } tdpt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/trial_division_prime_test.sv
// Top level of the trial division primality test.
// Each input request carries one signed value; each output request carries
// one flag that is 1 when the value is prime.
// Both channels use valid and stall; a request moves on a rising edge where
// valid is high and stall is low.
// Negative values, zero, one and even values are settled by classification alone.
// An odd value above two is divided by 3, 5, 7 and upward while the divisor
// does not exceed the quotient and the remainder is not zero, on one shared
// divider that produces one quotient bit per cycle.
// One value is in work at a time; the input stalls until its result is
// placed in the output register.
// The next value is accepted while the previous result still waits there.
// When the receiver stalls, the finished result holds in the output register
// and the next result waits inside the block until that register is free.
// Synchronous reset clears the control state and empties the output register.
`default_nettype none

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_is_prime
);

  localparam int W = VALUE_WIDTH;

  tdpt_state_t  state_r;
  logic [W-1:0] n_r;
  logic [W-1:0] d_r;
  logic         start_r;
  logic         res_r;
  logic         out_valid_r;
  logic         out_is_prime_r;
  logic         out_free;
  div_stat_t    div_stat;
  logic [W-1:0] div_quot;
  logic [W-1:0] div_rem;

  tdpt_div #(
    .W(W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (n_r),
    .divisor  (d_r),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign out_free     = !out_valid_r || !out_stall;
  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          start_r <= 1'b0;
          if (in_valid) begin
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (n_r[W-1] || (n_r <= W'(1)) || !n_r[0]) begin
            start_r <= 1'b0;
            state_r <= S_DONE;
          end else begin
            start_r <= 1'b1;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done && ((d_r > div_quot) || (div_rem == '0))) begin
            start_r <= 1'b0;
            state_r <= S_DONE;
          end else begin
            start_r <= div_stat.done;
          end
        end
        S_DONE: begin
          start_r <= 1'b0;
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          start_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      n_r <= in_value;
    end
    if (state_r == S_CLASS) begin
      d_r   <= W'(3);
      res_r <= !n_r[W-1] && (n_r == W'(2));
    end
    if (state_r == S_DIV && div_stat.done) begin
      d_r   <= d_r + W'(2);
      res_r <= (d_r > div_quot);
    end
    if (state_r == S_DONE && out_free) begin
      out_is_prime_r <= res_r;
    end
  end

  a_accept_class: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_CLASS)
    else $error("accepted request did not enter classification");

  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && div_stat.done |-> d_r[0] && (d_r >= W'(3)))
    else $error("trial divisor is not odd or is below three");

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> state_r == S_DIV && !div_stat.busy)
    else $error("divider started outside the division state");

  a_even_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_free |=> !out_is_prime_r || n_r[0] || (n_r == W'(2)))
    else $error("even value other than two reported as prime");

endmodule

`default_nettype wire

### rtl/core/tdpt_div.sv
// Radix-2 restoring divider that produces one quotient bit per cycle.
`default_nettype none

module tdpt_div
  import tdpt_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output div_stat_t         stat,
  output logic      [W-1:0] quot,
  output logic      [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  rem_r;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          qbit;
  logic [W-1:0]  rem_nxt;

  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = ~diff[W];
    if (qbit) begin
      rem_nxt = diff[W-1:0];
    end else begin
      rem_nxt = trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;
  assign rem       = rem_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && (cnt_r == CW'(W)))
    else $error("divider did not begin after start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !start |=> cnt_r == $past(cnt_r))
    else $error("divider counter moved while idle");

endmodule

`default_nettype wire
